// ===== hw/rtl/itoa_pkg.sv =====
// Package for the signed integer to decimal ASCII block.
// Holds widths, character codes, the sequencer state type and the converter interface structs.
// No dependencies.
package itoa_pkg;

  localparam int ValueWidth  = 32;
  localparam int NumDigits   = 10;
  localparam int BcdWidth    = 4 * NumDigits;
  localparam int BitCntWidth = $clog2(ValueWidth);
  localparam int RemWidth    = $clog2(NumDigits + 1);
  localparam int CharWidth   = 6;
  localparam int TdataWidth  = 8;

  localparam logic [CharWidth-1:0] MinusCode = 6'd45;
  localparam logic [CharWidth-1:0] DigitBase = 6'd48;
  localparam logic [3:0]           DabLimit  = 4'd5;
  localparam logic [3:0]           DabAdjust = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_DIGIT
  } itoa_state_t;

  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] mag;
  } dab_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

endpackage

// ===== hw/rtl/itoa_dabble.sv =====
// Binary to BCD converter, shift and add-3, one magnitude bit per cycle.
// Depends on itoa_pkg.
module itoa_dabble (
  input  logic                      clk,
  input  logic                      rst_n,
  input  itoa_pkg::dab_ctl_t        ctl,
  output itoa_pkg::dab_stat_t       stat,
  output logic [itoa_pkg::BcdWidth-1:0] bcd
);
  import itoa_pkg::*;

  logic [ValueWidth-1:0]  shift_r, shift_nxt;
  logic [BcdWidth-1:0]    bcd_r, bcd_nxt, adj;
  logic [BitCntWidth-1:0] cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= DabLimit) ? bcd_r[4*i +: 4] + DabAdjust
                                                     : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctl.start) begin
      shift_nxt = ctl.mag;
      bcd_nxt   = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {shift_r[ValueWidth-2:0], 1'b0};
      bcd_nxt   = {adj[BcdWidth-2:0], shift_r[ValueWidth-1]};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == BitCntWidth'(ValueWidth - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
    cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r) else $error("converter did not start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without a conversion");
  a_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> bcd_r[BcdWidth-1 -: 4] <= 4'd4) else $error("top digit out of range");
`endif

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii_top.sv =====
// Top level: signed 32-bit integer to decimal ASCII characters, most significant first.
// Depends on itoa_pkg and itoa_dabble.
//
//  channel | ports                  | tdata (low bit up)        | tuser/tlast
//  in      | in_tvalid/tready/tdata | value[31:0]               | -
//  out     | out_tvalid/tready/tdata| text_char[5:0], 2'b0 pad  | tlast = last_char
//
// One value is accepted, shifted bit by bit through the shift-add-3 converter and its digits
// loaded; the minus sign goes out if the value is negative, leading zeros are skipped one at a
// time (up to 9) before the skip state is left, and then the characters are sent.
// A stalled output holds the sequencer in the sign or digit state.
// Synchronous active-low reset clears the sequencer, the converter and the output valid.
// A new value is taken once the last character sits in the output register.
module signed_int_to_decimal_ascii_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [itoa_pkg::ValueWidth-1:0] in_tdata,   // value[31:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [itoa_pkg::TdataWidth-1:0] out_tdata,  // text_char[5:0], zero pad [7:6]
  output logic                            out_tlast   // last_char
);
  import itoa_pkg::*;

  itoa_state_t state_r, state_nxt;

  dab_ctl_t            dab_ctl;
  dab_stat_t           dab_stat;
  logic [BcdWidth-1:0] dab_bcd;

  logic                 neg_r;
  logic [BcdWidth-1:0]  dig_r, dig_nxt;
  logic [RemWidth-1:0]  rem_r, rem_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [CharWidth-1:0] ochar_r, ochar_nxt;
  logic                 olast_r, olast_nxt;

  logic                 accept;
  logic                 slot_free;
  logic                 top_zero;
  logic                 load_out;
  logic                 shift_dig;
  logic [3:0]           top_dig;

  assign accept    = in_tvalid && in_tready;
  assign slot_free = !ovalid_r || out_tready;
  assign top_dig   = dig_r[BcdWidth-1 -: 4];
  assign top_zero  = (top_dig == 4'd0) && (rem_r > RemWidth'(1));

  itoa_dabble u_dabble (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (dab_ctl),
    .stat (dab_stat),
    .bcd  (dab_bcd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CONV;
      ST_CONV:  if (dab_stat.done) state_nxt = neg_r ? ST_SIGN : ST_SKIP;
      ST_SIGN:  if (slot_free) state_nxt = ST_SKIP;
      ST_SKIP:  if (!top_zero) state_nxt = ST_DIGIT;
      ST_DIGIT: if (slot_free && rem_r == RemWidth'(1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    dab_ctl.start = 1'b0;
    dab_ctl.mag = in_tdata[ValueWidth-1] ? ~in_tdata + 1'b1 : in_tdata;
    load_out    = 1'b0;
    shift_dig   = 1'b0;
    ochar_nxt   = ochar_r;
    olast_nxt   = olast_r;
    case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        dab_ctl.start = in_tvalid;
      end
      ST_SIGN: begin
        load_out  = slot_free;
        ochar_nxt = MinusCode;
        olast_nxt = 1'b0;
      end
      ST_SKIP: begin
        shift_dig = top_zero;
      end
      ST_DIGIT: begin
        load_out  = slot_free;
        shift_dig = slot_free;
        ochar_nxt = DigitBase + {2'b00, top_dig};
        olast_nxt = (rem_r == RemWidth'(1));
      end
      default: ;
    endcase
  end

  always_comb begin
    dig_nxt = dig_r;
    rem_nxt = rem_r;
    if (state_r == ST_CONV && dab_stat.done) begin
      dig_nxt = dab_bcd;
      rem_nxt = RemWidth'(NumDigits);
    end else if (shift_dig) begin
      dig_nxt = {dig_r[BcdWidth-5:0], 4'd0};
      rem_nxt = rem_r - 1'b1;
    end
    ovalid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : ovalid_r);
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    if (accept) neg_r <= in_tdata[ValueWidth-1];
    if (load_out) begin
      ochar_r <= ochar_nxt;
      olast_r <= olast_nxt;
    end
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rem_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rem_r    <= rem_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(TdataWidth - CharWidth){1'b0}}, ochar_r};
  assign out_tlast  = olast_r;

`ifndef SYNTH
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dab_stat.done |-> state_r == ST_CONV) else $error("conversion done outside CONV");
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SKIP || state_r == ST_DIGIT) |-> rem_r != '0)
    else $error("digit count underflow");
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[CharWidth-1:0] == MinusCode ||
                    (out_tdata[CharWidth-1:0] >= DigitBase &&
                     out_tdata[CharWidth-1:0] <= DigitBase + 6'd9)))
    else $error("bad character code");
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[CharWidth-1:0] == MinusCode) |-> !out_tlast)
    else $error("minus sign flagged last");
`endif

endmodule

// ===== test/signed_int_to_decimal_ascii_top_tb.sv =====
// Testbench for signed_int_to_decimal_ascii_top: signed 32-bit values in, decimal ASCII out.
// Directed table then random values under varying idle patterns, checked per character.
// Depends on itoa_pkg and the RTL of signed_int_to_decimal_ascii_top.
module signed_int_to_decimal_ascii_top_tb;
  import itoa_pkg::*;

  localparam int NumDirected = 17;
  localparam int NumRandom   = 363;
  localparam int NumValues   = NumDirected + NumRandom;
  localparam int DrainCycles = 60;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } text_char_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [ValueWidth-1:0] in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TdataWidth-1:0] out_tdata;
  logic                  out_tlast;

  text_char_t pending_chars[$];
  int         mismatches   = 0;
  int         cycle_count  = 0;
  int         send_idle_pct = 22;
  int         recv_idle_pct = 54;

  logic [ValueWidth-1:0] dir_value [NumDirected] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0001, 32'd1000000000, 32'd999999999, -32'd999999999, 32'd12345,
    32'h5555_5555, 32'hAAAA_AAAA, -32'd100, 32'd100
  };
  string dir_text [NumDirected] = '{
    "0", "1", "-1", "9", "10", "-10", "2147483647", "-2147483648",
    "-2147483647", "1000000000", "999999999", "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic void render_decimal(input logic [ValueWidth-1:0] value);
    logic                  neg;
    logic [ValueWidth-1:0] mag;
    logic [3:0]            digits [NumDigits];
    int                    n;
    text_char_t            c;
    neg = value[ValueWidth-1];
    mag = neg ? -value : value;
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < NumDigits);
    if (neg) begin
      c.ch = MinusCode;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.ch = DigitBase + CharWidth'(digits[i]);
      c.last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void expect_text(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.ch = CharWidth'(text.getc(i));
      c.last = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [ValueWidth-1:0] random_value();
    int unsigned           mode;
    int unsigned           k;
    logic [ValueWidth-1:0] p10;
    logic [ValueWidth-1:0] mag;
    mode = $urandom_range(0, 3);
    k = $urandom_range(0, 9);
    p10 = 1;
    repeat (k) p10 = p10 * 10;
    case (mode)
      0: begin
        return $urandom;
      end
      1: begin
        mag = $urandom_range(p10, (k == 9) ? 32'h7FFF_FFFF : p10 * 10 - 1);
      end
      2: begin
        mag = p10 + $urandom_range(0, 2) - 1;
      end
      default: begin
        mag = $urandom_range(0, 9);
      end
    endcase
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return mag;
  endfunction

  task automatic send_value(input logic [ValueWidth-1:0] value, input string text,
                            input bit typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) expect_text(text);
    else render_decimal(value);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("signed_int_to_decimal_ascii_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b", out_tdata, out_tlast));
        end else begin
          want = pending_chars.pop_front();
          if (out_tdata[CharWidth-1:0] !== want.ch)
            report_mismatch($sformatf("char %0d, want %0d", out_tdata[CharWidth-1:0], want.ch));
          if (out_tdata[TdataWidth-1:CharWidth] !== '0)
            report_mismatch($sformatf("pad bits %b", out_tdata[TdataWidth-1:CharWidth]));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int idx = 0; idx < NumValues; idx++) begin
      if (idx == NumValues / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 22;
      end else if (idx == 2 * NumValues / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (idx < NumDirected)
        send_value(dir_value[idx], dir_text[idx], dir_text[idx].len() != 0);
      else
        send_value(random_value(), "", 1'b0);
    end
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii_top_tb: clean");
    end else begin
      $display("signed_int_to_decimal_ascii_top_tb: errors");
    end
    $finish;
  end

endmodule
